FILE: src/tilp_pkg.sv
// ----------------------------------------------------------------------------
// tilp_pkg
// Shared types and codes for the trie insert / lookup / preorder unit.
// ----------------------------------------------------------------------------
package tilp_pkg;

    localparam int FIELD_W   = 10;
    localparam int FIELD_MAX = 1023;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_BUILD  = 2'd2,
        ACT_PEEK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_STALE    = 2'd3
    } t_status;

    // One classified request as held in the front queue.
    typedef struct packed {
        t_action              action;
        logic [3:0]           symbol;
        logic                 sym_valid;
        logic                 last;
        logic [FIELD_W-1:0]   node;
        logic                 sym_oob;
        logic                 node_oob;
    } t_req;

endpackage

FILE: src/trie_insert_lookup_preorder_unit.sv
// ----------------------------------------------------------------------------
// trie_insert_lookup_preorder_unit
// Array trie with insert, lookup, preorder build and child peek.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel, one key symbol per request; tlast
// marks the final request of a key. Results leave on m_axis, one per key end,
// build or peek. Requests go into a two-entry queue, so the input can take up
// to two more requests while a result waits for m_axis_tready.
// Steps per request (each child-table read is registered):
//   insert/lookup symbol: child-slot read and finish; allocation adds the
//   row clear and the link write; a lookup hit adds the order read.
//   peek: a child read, none if the node is unallocated or out of range.
//   build: for each node in the trie, a visit, a read per child, a pop.
// A new request is started only when the result register is empty, so a
// stalled receiver holds the engine after its current request.
// After reset the root row is cleared before the first request is taken
// from the queue; the trie then holds only the root and no numbering exists.
// ----------------------------------------------------------------------------
module trie_insert_lookup_preorder_unit #(
    parameter int ALPHABET  = 10,
    parameter int MAX_NODES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // symbol[3:0], node[13:4]
    input  logic [2:0]  s_axis_tuser,   // action[1:0], symbol_valid[2]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // node_index[9:0], order[19:10]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import tilp_pkg::*;

    logic       w_req_valid, w_req_pop;
    t_req       w_req;
    logic [9:0] w_node_index, w_order;

    tilp_front #(.ALPHABET(ALPHABET), .MAX_NODES(MAX_NODES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_action    (t_action'(s_axis_tuser[1:0])),
        .i_symbol    (s_axis_tdata[3:0]),
        .i_sym_valid (s_axis_tuser[2]),
        .i_last      (s_axis_tlast),
        .i_node      (s_axis_tdata[13:4]),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_pop   (w_req_pop)
    );

    tilp_engine #(.ALPHABET(ALPHABET), .MAX_NODES(MAX_NODES)) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (w_req_valid),
        .i_req        (w_req),
        .o_req_pop    (w_req_pop),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_node_index (w_node_index),
        .o_order      (w_order),
        .o_status     (m_axis_tuser)
    );

    assign m_axis_tdata = {4'd0, w_order, w_node_index};
endmodule

FILE: src/tilp_ram.sv
// ----------------------------------------------------------------------------
// tilp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tilp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/tilp_front.sv
// ----------------------------------------------------------------------------
// tilp_front
// Request intake: range checks on symbol and node, two-entry request queue.
// ----------------------------------------------------------------------------
module tilp_front #(
    parameter int ALPHABET  = 10,
    parameter int MAX_NODES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tilp_pkg::t_action    i_action,
    input  logic [3:0]           i_symbol,
    input  logic                 i_sym_valid,
    input  logic                 i_last,
    input  logic [9:0]           i_node,
    output logic                 o_req_valid,
    output tilp_pkg::t_req       o_req,
    input  logic                 i_req_pop
);
    import tilp_pkg::*;

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_req       w_in;
    logic       w_push;

    always_comb begin
        w_in.action    = i_action;
        w_in.symbol    = i_symbol;
        w_in.sym_valid = i_sym_valid;
        w_in.last      = i_last;
        w_in.node      = i_node;
        w_in.sym_oob   = (32'(i_symbol) >= ALPHABET);
        w_in.node_oob  = (32'(i_node) >= MAX_NODES);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_req_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_req_pop);
        end
    end
endmodule

FILE: src/tilp_engine.sv
// ----------------------------------------------------------------------------
// tilp_engine
// Back end: trie walk, row allocation, preorder build, peek, result register.
// ----------------------------------------------------------------------------
module tilp_engine #(
    parameter int ALPHABET  = 10,
    parameter int MAX_NODES = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  tilp_pkg::t_req  i_req,
    output logic            o_req_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [9:0]      o_node_index,
    output logic [9:0]      o_order,
    output logic [1:0]      o_status
);
    import tilp_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = NW + 1;
    localparam int KW  = $clog2(ALPHABET);
    localparam int CD  = MAX_NODES * ALPHABET;
    localparam int AW  = $clog2(CD);

    typedef enum logic [3:0] {
        S_IDLE, S_W_RESP, S_CLR, S_LINK, S_FIN, S_O_RESP, S_P_RESP,
        S_B_VISIT, S_B_ISS, S_B_CHK, S_B_POP, S_B_POPW
    } t_state;

    t_state        r_state;
    t_action       r_act;
    logic          r_last;
    logic [NW-1:0] r_walk, r_newc, r_bpos;
    logic [1:0]    r_fail;
    logic [CW-1:0] r_node_count, r_numbered, r_t, r_sp;
    logic [KW-1:0] r_k;
    logic          r_link;
    logic [AW-1:0] r_slot;
    logic          r_out_valid;
    logic [9:0]    r_out_node, r_out_order;
    t_status       r_out_status;

    logic          c_we;
    logic [AW-1:0] c_waddr, c_raddr, w_walk_addr;
    logic [NW-1:0] c_wdata, c_rdata;
    logic          o_we;
    logic [NW-1:0] ot_rdata;
    logic          s_we;
    logic [NW-1:0] s_rdata;
    logic          w_push_ok;
    logic          w_free;

    function automatic logic [9:0] sat_cnt(input logic [CW-1:0] v);
        return (32'(v) > FIELD_MAX) ? 10'(FIELD_MAX) : 10'(v);
    endfunction

    assign w_free      = !r_out_valid;
    assign o_req_pop   = (r_state == S_IDLE) && i_req_valid && w_free;
    assign w_walk_addr = AW'(r_walk * ALPHABET + i_req.symbol);
    assign w_push_ok   = (c_rdata != '0) && (32'(r_sp) < MAX_NODES);

    always_comb begin
        c_we    = 1'b0;
        c_waddr = r_slot;
        c_wdata = r_newc;
        c_raddr = w_walk_addr;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.action == ACT_PEEK) begin
                    c_raddr = AW'(NW'(i_req.node) * ALPHABET + i_req.symbol);
                end
            end
            S_CLR: begin
                c_we    = 1'b1;
                c_waddr = AW'(r_newc * ALPHABET + r_k);
                c_wdata = '0;
            end
            S_LINK: c_we = 1'b1;
            S_B_ISS: c_raddr = AW'(r_bpos * ALPHABET + r_k);
            default: ;
        endcase
    end

    assign o_we = (r_state == S_B_VISIT);
    assign s_we = (r_state == S_B_CHK) && w_push_ok;

    tilp_ram #(.WIDTH(NW), .DEPTH(CD)) u_child (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    tilp_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_order (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(r_bpos), .i_wdata(NW'(r_t)),
        .i_raddr(r_walk), .o_rdata(ot_rdata)
    );

    tilp_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(NW'(r_sp)), .i_wdata(c_rdata),
        .i_raddr(NW'(r_sp - CW'(1))), .o_rdata(s_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;   // clear the root row first
            r_k          <= '0;
            r_newc       <= '0;
            r_link       <= 1'b0;
            r_node_count <= CW'(1);
            r_numbered   <= '0;
            r_walk       <= '0;
            r_fail       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_req_pop) begin
                        r_act  <= i_req.action;
                        r_last <= i_req.last;
                        unique case (i_req.action)
                            ACT_BUILD: begin
                                r_t     <= '0;
                                r_sp    <= '0;
                                r_bpos  <= '0;
                                r_state <= S_B_VISIT;
                            end
                            ACT_PEEK: begin
                                r_out_order  <= '0;
                                r_out_node   <= '0;
                                if (i_req.node_oob || i_req.sym_oob) begin
                                    r_out_status <= ST_NOTFOUND;
                                    r_out_valid  <= 1'b1;
                                end else if (32'(i_req.node) >= 32'(r_node_count)) begin
                                    r_out_status <= ST_OK;
                                    r_out_valid  <= 1'b1;
                                end else begin
                                    r_out_status <= ST_OK;
                                    r_state      <= S_P_RESP;
                                end
                            end
                            default: begin
                                if (i_req.sym_valid && r_fail == 2'd0) begin
                                    if (i_req.sym_oob) begin
                                        r_fail  <= 2'(ST_NOTFOUND);
                                        r_state <= S_FIN;
                                    end else begin
                                        r_slot  <= w_walk_addr;
                                        r_state <= S_W_RESP;
                                    end
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                        endcase
                    end
                end
                S_W_RESP: begin
                    r_state <= S_FIN;
                    if (c_rdata != '0) begin
                        r_walk <= c_rdata;
                    end else if (r_act == ACT_LOOKUP) begin
                        r_fail <= 2'(ST_NOTFOUND);
                    end else if (32'(r_node_count) >= MAX_NODES) begin
                        r_fail <= 2'(ST_FULL);
                    end else begin
                        r_newc       <= NW'(r_node_count);
                        r_node_count <= r_node_count + CW'(1);
                        r_k          <= '0;
                        r_link       <= 1'b1;
                        r_state      <= S_CLR;
                    end
                end
                S_CLR: begin
                    if (r_k == KW'(ALPHABET - 1)) begin
                        r_state <= r_link ? S_LINK : S_IDLE;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_LINK: begin
                    r_walk  <= r_newc;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                    if (r_last) begin
                        r_walk      <= '0;
                        r_fail      <= '0;
                        r_out_order <= '0;
                        if (r_act == ACT_INSERT) begin
                            r_out_node   <= (r_fail != 2'd0) ? 10'd0 : 10'(r_walk);
                            r_out_status <= t_status'(r_fail);
                            r_out_valid  <= 1'b1;
                        end else if (r_fail != 2'd0) begin
                            r_out_node   <= '0;
                            r_out_status <= ST_NOTFOUND;
                            r_out_valid  <= 1'b1;
                        end else if (CW'(r_walk) >= r_numbered) begin
                            r_out_node   <= 10'(r_walk);
                            r_out_status <= ST_STALE;
                            r_out_valid  <= 1'b1;
                        end else begin
                            r_out_node   <= 10'(r_walk);
                            r_out_status <= ST_OK;
                            r_state      <= S_O_RESP;
                        end
                    end
                end
                S_O_RESP: begin
                    r_out_order <= sat_cnt(CW'(ot_rdata));
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_P_RESP: begin
                    r_out_node  <= 10'(c_rdata);
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_B_VISIT: begin
                    r_t     <= r_t + CW'(1);
                    r_k     <= KW'(ALPHABET - 1);
                    r_state <= S_B_ISS;
                end
                S_B_ISS: r_state <= S_B_CHK;
                S_B_CHK: begin
                    if (w_push_ok) r_sp <= r_sp + CW'(1);
                    if (r_k == '0) begin
                        r_state <= S_B_POP;
                    end else begin
                        r_k     <= r_k - KW'(1);
                        r_state <= S_B_ISS;
                    end
                end
                S_B_POP: begin
                    if (r_sp == '0) begin
                        r_numbered   <= r_t;
                        r_out_node   <= '0;
                        r_out_order  <= sat_cnt(r_t);
                        r_out_status <= ST_OK;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_sp    <= r_sp - CW'(1);
                        r_state <= S_B_POPW;
                    end
                end
                S_B_POPW: begin
                    r_bpos  <= s_rdata;
                    r_state <= S_B_VISIT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_node_index = r_out_node;
    assign o_order      = r_out_order;
    assign o_status     = r_out_status;
endmodule

FILE: test/tilp_checker.sv
// ----------------------------------------------------------------------------
// tilp_checker
// Scoreboard for the trie insert / lookup / preorder unit.
// ----------------------------------------------------------------------------
// Watches both stream channels. Every accepted request is run through a local
// copy of the trie (child rows, preorder ranks, walk cursor, key error).
// Whatever result that request must produce is queued. Every accepted result
// is checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module tilp_checker
    import tilp_pkg::*;
#(
    parameter int ALPHABET  = 10,
    parameter int MAX_NODES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,    // symbol[3:0], node[13:4]
    input  logic [2:0]  i_s_tuser,    // action[1:0], symbol_valid[2]
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,    // node_index[9:0], order[19:10]
    input  logic [1:0]  i_m_tuser,    // status[1:0]
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_full_seen,
    output int          o_stale_seen,
    output int          o_builds
);

    typedef struct packed {
        logic [FIELD_W-1:0] node_index;
        logic [FIELD_W-1:0] order;
        t_status            status;
    } t_result;

    t_result            results_due[$];

    logic [FIELD_W-1:0] kids [0:ALPHABET*MAX_NODES-1];
    logic [FIELD_W-1:0] rank [0:MAX_NODES-1];
    int                 dfs_stack [0:MAX_NODES-1];
    int                 node_total;
    int                 ranked;
    int                 cursor;
    logic [1:0]         key_err;

    assign o_pending = results_due.size();

    function automatic logic [FIELD_W-1:0] clip(input int v);
        return (v > FIELD_MAX) ? FIELD_W'(FIELD_MAX) : FIELD_W'(v);
    endfunction

    // Preorder numbering, children visited in ascending symbol order.
    task automatic renumber();
        int sp, cnt, pos, k, c;
        sp = 1;
        cnt = 0;
        dfs_stack[0] = 0;
        while (sp != 0) begin
            sp--;
            pos = dfs_stack[sp];
            rank[pos] = FIELD_W'(cnt);
            cnt++;
            for (k = ALPHABET - 1; k >= 0; k--) begin
                c = kids[pos*ALPHABET + k];
                if (c != 0 && sp < MAX_NODES) begin
                    dfs_stack[sp] = c;
                    sp++;
                end
            end
        end
        ranked = cnt;
    endtask

    task automatic predict(input t_action act, input logic [3:0] sym, input logic sv,
                           input logic lst, input logic [FIELD_W-1:0] nd);
        t_result r;
        int slot, c, k;
        r = '{node_index: '0, order: '0, status: ST_OK};
        case (act)
            ACT_BUILD: begin
                renumber();
                o_builds++;
                r.order = clip(ranked);
                results_due.insert(results_due.size(), r);
            end
            ACT_PEEK: begin
                if (sym >= ALPHABET || nd >= MAX_NODES) r.status = ST_NOTFOUND;
                else r.node_index = kids[nd*ALPHABET + sym];
                results_due.insert(results_due.size(), r);
            end
            default: begin
                if (sv && key_err == 0) begin
                    if (sym >= ALPHABET) begin
                        key_err = ST_NOTFOUND;
                    end else begin
                        slot = cursor*ALPHABET + sym;
                        c = kids[slot];
                        if (c != 0) begin
                            cursor = c;
                        end else if (act == ACT_LOOKUP) begin
                            key_err = ST_NOTFOUND;
                        end else if (node_total >= MAX_NODES) begin
                            key_err = ST_FULL;
                        end else begin
                            c = node_total;
                            node_total++;
                            for (k = 0; k < ALPHABET; k++) kids[c*ALPHABET + k] = '0;
                            kids[slot] = FIELD_W'(c);
                            cursor = c;
                        end
                    end
                end
                if (lst) begin
                    if (key_err != 0) begin
                        r.status = (act == ACT_INSERT) ? t_status'(key_err) : ST_NOTFOUND;
                    end else begin
                        r.node_index = FIELD_W'(cursor);
                        if (act == ACT_LOOKUP) begin
                            if (cursor >= ranked) r.status = ST_STALE;
                            else r.order = rank[cursor];
                        end
                    end
                    cursor = 0;
                    key_err = 0;
                    results_due.insert(results_due.size(), r);
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < ALPHABET*MAX_NODES; i++) kids[i] = '0;
            node_total = 1;
            ranked = 0;
            cursor = 0;
            key_err = 0;
            results_due.delete();
            o_fail_count = 0;
            o_checked = 0;
            o_full_seen = 0;
            o_stale_seen = 0;
            o_builds = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.node_index = i_m_tdata[9:0];
                got.order      = i_m_tdata[19:10];
                got.status     = t_status'(i_m_tuser);
                o_checked++;
                if (results_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result idx=%0d ord=%0d st=%0d",
                                 $realtime, got.node_index, got.order, got.status);
                end else begin
                    want = results_due.pop_front();
                    if (want.status == ST_FULL) o_full_seen++;
                    if (want.status == ST_STALE) o_stale_seen++;
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch idx %0d/%0d ord %0d/%0d st %0d/%0d (exp/act)",
                                     $realtime, want.node_index, got.node_index,
                                     want.order, got.order, want.status, got.status);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict(t_action'(i_s_tuser[1:0]), i_s_tdata[3:0], i_s_tuser[2],
                        i_s_tlast, i_s_tdata[13:4]);
        end
    end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the trie insert / lookup / preorder unit.
// ----------------------------------------------------------------------------
// A directed opening covers empty keys, stale and fresh numbering, misses,
// bad symbols, peeks and keys interrupted by builds or mixed actions. Random
// keys follow, mostly inserts and lookups of stored keys. A fill phase then
// runs the node table out. Sender bursts and receiver stalls vary throughout,
// and one long receiver hold-off backs the unit up. Results are checked by
// tilp_checker.
// ----------------------------------------------------------------------------
module tb;
    import tilp_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int fail_count, pending, checked, full_seen, stale_seen, builds;
    int cycles;
    int sent;
    int burst_left;
    bit hold_done;

    logic [3:0] key_sym [0:511][0:15];
    int         key_len [0:511];
    int         n_keys;

    trie_insert_lookup_preorder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tilp_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_seen  (full_seen),
        .o_stale_seen (stale_seen),
        .o_builds     (builds)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("tb: FAIL");
            $finish;
        end
    end

    // Receiver: stall pattern picked at random from four modes; one long hold-off.
    initial begin
        int mode;
        mode = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && sent >= 300) begin
                m_axis_tready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_done = 1'b1;
            end
            if (cycles % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_axis_tready = 1'b1;
                1: m_axis_tready = ($urandom_range(0, 1) == 0);
                2: m_axis_tready = ($urandom_range(0, 9) < 8);
                default: m_axis_tready = ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // Called and returns just after a falling edge.
    task automatic send_item(input t_action act, input logic [3:0] sym, input logic sv,
                             input logic lst, input logic [9:0] nd);
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, nd, sym};
        s_axis_tuser  = {sv, act};
        s_axis_tlast  = lst;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
            @(negedge i_clk);
        end
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [3:0] any_symbol();
        return ($urandom_range(0, 29) == 0) ? 4'($urandom_range(10, 15))
                                            : 4'($urandom_range(0, 9));
    endfunction

    // One key; reuse picks a stored key, sometimes cut short or extended.
    task automatic run_key(input t_action act, input int len, input bit reuse);
        int k, i;
        logic [3:0] s;
        t_action a;
        k = (reuse && n_keys > 0) ? $urandom_range(0, n_keys - 1) : -1;
        if (k >= 0) begin
            len = key_len[k];
            if ($urandom_range(0, 9) == 0) len = len + 1;
            else if ($urandom_range(0, 9) == 0 && len > 0) len = len - 1;
        end
        if (len == 0) begin
            send_item(act, 4'($urandom), 1'b0, 1'b1, 10'($urandom));
        end
        for (i = 0; i < len; i++) begin
            s = (k >= 0 && i < key_len[k]) ? key_sym[k][i] : any_symbol();
            if (act == ACT_INSERT && k < 0 && n_keys < 512 && i < 16) key_sym[n_keys][i] = s;
            a = act;
            if ($urandom_range(0, 24) == 0) a = (act == ACT_INSERT) ? ACT_LOOKUP : ACT_INSERT;
            if ($urandom_range(0, 39) == 0)
                send_item(ACT_BUILD, 4'($urandom), 1'($urandom), 1'($urandom), 10'($urandom));
            if ($urandom_range(0, 19) == 0)
                send_item(a, 4'($urandom), 1'b0, 1'b0, 10'($urandom));
            send_item(a, s, 1'b1, i == len - 1, 10'($urandom));
        end
        if (act == ACT_INSERT && k < 0 && n_keys < 512 && len <= 16) begin
            key_len[n_keys] = len;
            n_keys++;
        end
    endtask

    task automatic peek_random();
        logic [9:0] nd;
        nd = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 40)) : 10'($urandom);
        send_item(ACT_PEEK, any_symbol(), 1'($urandom), 1'($urandom), nd);
    endtask

    initial begin
        int r;
        int i;
        cycles = 0;
        sent = 0;
        burst_left = 0;
        n_keys = 0;
        hold_done = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed opening
        send_item(ACT_INSERT, 4'd0, 1'b0, 1'b1, 10'd0);      // empty key
        send_item(ACT_LOOKUP, 4'd15, 1'b0, 1'b1, 10'h3FF);   // empty, nothing numbered yet
        send_item(ACT_INSERT, 4'd9, 1'b1, 1'b0, 10'h3FF);
        send_item(ACT_INSERT, 4'd0, 1'b1, 1'b0, 10'd0);
        send_item(ACT_INSERT, 4'd3, 1'b1, 1'b1, 10'h2AA);
        send_item(ACT_LOOKUP, 4'd9, 1'b1, 1'b1, 10'd0);      // stale
        send_item(ACT_BUILD, 4'd0, 1'b0, 1'b0, 10'd0);
        send_item(ACT_LOOKUP, 4'd9, 1'b1, 1'b0, 10'h155);
        send_item(ACT_LOOKUP, 4'd0, 1'b1, 1'b0, 10'd0);
        send_item(ACT_LOOKUP, 4'd3, 1'b1, 1'b1, 10'd0);      // hit
        send_item(ACT_LOOKUP, 4'd4, 1'b1, 1'b1, 10'd0);      // miss
        send_item(ACT_INSERT, 4'd15, 1'b1, 1'b0, 10'd0);     // bad symbol fails key
        send_item(ACT_INSERT, 4'd1, 1'b1, 1'b1, 10'd0);
        send_item(ACT_LOOKUP, 4'd12, 1'b1, 1'b1, 10'd0);
        send_item(ACT_PEEK, 4'd9, 1'b0, 1'b0, 10'd0);
        send_item(ACT_PEEK, 4'd13, 1'b1, 1'b1, 10'd1);
        send_item(ACT_PEEK, 4'd0, 1'b0, 1'b0, 10'h3FF);
        send_item(ACT_INSERT, 4'd9, 1'b1, 1'b0, 10'd0);      // mixed walk
        send_item(ACT_BUILD, 4'd7, 1'b1, 1'b1, 10'd0);       // build mid key
        send_item(ACT_LOOKUP, 4'd0, 1'b1, 1'b0, 10'd0);
        send_item(ACT_INSERT, 4'd2, 1'b0, 1'b0, 10'd0);
        send_item(ACT_INSERT, 4'd8, 1'b1, 1'b1, 10'd0);
        send_item(ACT_LOOKUP, 4'd0, 1'b1, 1'b1, 10'd0);      // miss, root has no child 0

        // random keys
        while (sent < 250) begin
            r = $urandom_range(0, 99);
            if (r < 45) run_key(ACT_INSERT, $urandom_range(0, 8), $urandom_range(0, 4) == 0);
            else if (r < 80) run_key(ACT_LOOKUP, $urandom_range(0, 8), $urandom_range(0, 3) != 0);
            else if (r < 83) send_item(ACT_BUILD, 4'($urandom), 1'($urandom), 1'($urandom),
                                       10'($urandom));
            else if (r < 93) peek_random();
            else send_item(t_action'($urandom_range(0, 3)), 4'($urandom), 1'($urandom),
                           1'($urandom), 10'($urandom));
        end

        // run the node table out with long fresh keys, then work on a full trie
        while (sent < 1420) begin
            for (i = 0; i < 12; i++)
                send_item(ACT_INSERT, 4'($urandom_range(0, 9)), 1'b1, i == 11,
                          10'($urandom));
        end
        send_item(ACT_BUILD, 4'd0, 1'b0, 1'b0, 10'd0);
        repeat (20) begin
            r = $urandom_range(0, 2);
            if (r == 0) run_key(ACT_LOOKUP, 0, 1'b1);
            else if (r == 1) run_key(ACT_INSERT, $urandom_range(1, 8), 1'b0);
            else peek_random();
        end
        s_axis_tvalid = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("tb: %0d requests sent, %0d results checked, %0d builds", sent, checked, builds);
        $display("tb: %0d table-full and %0d stale results seen", full_seen, stale_seen);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: %0d mismatches", fail_count);
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
